// File: design/migtt_pkg.sv
`default_nettype none

package migtt_pkg;

  localparam int TT_W  = 32;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;
  localparam int LC_W  = 3;

  localparam logic [LC_W-1:0]  LEAF_COUNT_RST = 3'd5;
  localparam logic [CNT_W-1:0] CNT_MAX        = 7'd127;

  // leaf patterns; leaf 0 is constant one over the low half
  localparam logic [TT_W-1:0] LEAF_PAT_0 = 32'h0000_FFFF;
  localparam logic [TT_W-1:0] LEAF_PAT_1 = 32'h0000_AAAA;
  localparam logic [TT_W-1:0] LEAF_PAT_2 = 32'h0000_CCCC;
  localparam logic [TT_W-1:0] LEAF_PAT_3 = 32'h0000_F0F0;
  localparam logic [TT_W-1:0] LEAF_PAT_4 = 32'h0000_FF00;

  typedef enum logic [1:0] {
    OP_MAJ   = 2'd0,
    OP_CONST = 2'd1,
    OP_VAR   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // per-child operand source, resolved when the word is accepted
  typedef struct packed {
    logic            use_mem;
    logic            use_fwd;
    logic            inv;
    logic [TT_W-1:0] leaf_val;
  } child_src_t;

  function automatic logic [TT_W-1:0] leaf_pattern(input logic [IDX_W-1:0] idx);
    logic [TT_W-1:0] pat;
    case (idx)
      6'd0:    pat = LEAF_PAT_0;
      6'd1:    pat = LEAF_PAT_1;
      6'd2:    pat = LEAF_PAT_2;
      6'd3:    pat = LEAF_PAT_3;
      6'd4:    pat = LEAF_PAT_4;
      default: pat = '0;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// File: design/mig_truth_table_eval.sv
`default_nettype none

// Channel | Ports                                           | Moves
// --------+-------------------------------------------------+---------------------------
// in      | in_valid/in_ready, in_operation .. in_last_node | one graph node word
// out     | out_valid/out_ready, out_truth_table            | root truth table word
// cfg     | cfg_wr_en, cfg_leaf_count                       | leaf count, no handshake
//
// One word per cycle sustained. Two-stage pipe: the accept edge issues the
// child reads to the node store, the next stage combines and writes back.
// out_valid rises once a result word has passed the stage 1 regs and then the output reg.
// A read of the entry written at the same edge is forwarded from a bypass reg.
// Sync reset, active low: leaf count 5, node counter 5; the store is not cleared.
// Stalls only when a result is waiting in stage 1 and the output reg is full.
module mig_truth_table_eval
  import migtt_pkg::*;
#(
  parameter int MAX_NODES = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // configuration
  input  wire logic             cfg_wr_en,
  input  wire logic [LC_W-1:0]  cfg_leaf_count,
  // input channel
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_operation,
  input  wire logic [IDX_W-1:0] in_child_a_index,
  input  wire logic             in_child_a_invert,
  input  wire logic [IDX_W-1:0] in_child_b_index,
  input  wire logic             in_child_b_invert,
  input  wire logic [IDX_W-1:0] in_child_c_index,
  input  wire logic             in_child_c_invert,
  input  wire logic [2:0]       in_variable_number,
  input  wire logic             in_root_invert,
  input  wire logic             in_last_node,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [TT_W-1:0]       out_truth_table
);

  localparam int AW = $clog2(MAX_NODES);

  // ---------------------------------------------------------------------------
  // Node store: two copies written together, copy 0 serves children a/b,
  // copy 1 serves child c. Read data registered on accept.
  // ---------------------------------------------------------------------------
  logic [TT_W-1:0] mem0 [MAX_NODES];
  logic [TT_W-1:0] mem1 [MAX_NODES];
  logic [TT_W-1:0] rd_a_r, rd_b_r, rd_c_r;

  // control state
  logic [LC_W-1:0]  leaf_count_r;
  logic [CNT_W-1:0] node_idx_r, node_idx_nxt;

  // stage 1
  logic             s1_valid_r;
  logic             s1_is_maj_r;
  logic             s1_emit_r;
  logic             s1_rinv_r;
  logic [TT_W-1:0]  s1_const_r;
  logic             s1_wr_en_r;
  logic [CNT_W-1:0] s1_wr_idx_r;
  child_src_t       s1_child_r [3];
  logic [TT_W-1:0]  fwd_data_r;

  logic             s1_fire;
  logic             in_accept;
  op_t              op;

  logic [IDX_W-1:0] child_idx [3];
  logic             child_inv [3];
  child_src_t       child_src [3];
  logic [AW-1:0]    rd_addr [3];
  logic [AW-1:0]    wr_addr;
  logic [TT_W-1:0]  child_val [3];
  logic [TT_W-1:0]  maj_val;
  logic [TT_W-1:0]  s1_result;
  logic [TT_W-1:0]  const_val;
  logic [IDX_W+AW-1:0] rd_ext [3];
  logic [CNT_W+AW-1:0] wr_ext;

  logic             out_valid_r;
  logic [TT_W-1:0]  out_tt_r;

  assign op = op_t'(in_operation);

  assign child_idx[0] = in_child_a_index;
  assign child_idx[1] = in_child_b_index;
  assign child_idx[2] = in_child_c_index;
  assign child_inv[0] = in_child_a_invert;
  assign child_inv[1] = in_child_b_invert;
  assign child_inv[2] = in_child_c_invert;

  // stage 1 retires unless it carries a result and the output reg is stuck
  assign s1_fire   = s1_valid_r && (!s1_emit_r || !out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_fire;
  assign in_accept = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Stage 0: resolve each child's source, issue store reads
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic is_leaf;
      logic in_range;
      is_leaf  = child_idx[k] < {{(IDX_W-LC_W){1'b0}}, leaf_count_r};
      in_range = 32'(child_idx[k]) < MAX_NODES;
      child_src[k].use_mem  = !is_leaf && in_range;
      // entry written at this very edge by stage 1 is not yet in the store
      child_src[k].use_fwd  = !is_leaf && in_range && s1_fire && s1_is_maj_r &&
                              s1_wr_en_r &&
                              ({1'b0, child_idx[k]} == s1_wr_idx_r);
      child_src[k].inv      = child_inv[k];
      child_src[k].leaf_val = is_leaf ? leaf_pattern(child_idx[k]) : '0;
      rd_ext[k]  = {{AW{1'b0}}, child_idx[k]};
      rd_addr[k] = rd_ext[k][AW-1:0];
    end
  end

  // result of the graph-level operations, known at accept
  always_comb begin
    if (op == OP_CONST) begin
      const_val = {TT_W{~in_root_invert}};
    end else begin
      const_val = leaf_pattern({3'b000, in_variable_number}) ^ {TT_W{in_root_invert}};
    end
  end

  // node counter
  always_comb begin
    node_idx_nxt = node_idx_r;
    if (in_accept) begin
      case (op)
        OP_CONST, OP_VAR: begin
          node_idx_nxt = {{(CNT_W-LC_W){1'b0}}, leaf_count_r};
        end
        OP_MAJ: begin
          if (in_last_node) begin
            node_idx_nxt = {{(CNT_W-LC_W){1'b0}}, leaf_count_r};
          end else if (node_idx_r < CNT_MAX) begin
            node_idx_nxt = node_idx_r + 7'd1;
          end
        end
        default: begin
          node_idx_nxt = node_idx_r;
        end
      endcase
    end
    // config write restarts the counter; taken last
    if (cfg_wr_en) begin
      node_idx_nxt = {{(CNT_W-LC_W){1'b0}}, cfg_leaf_count};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_count_r <= LEAF_COUNT_RST;
      node_idx_r   <= {{(CNT_W-LC_W){1'b0}}, LEAF_COUNT_RST};
    end else begin
      if (cfg_wr_en) begin
        leaf_count_r <= cfg_leaf_count;
      end
      node_idx_r <= node_idx_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= (op != OP_NONE);
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_is_maj_r <= (op == OP_MAJ);
      s1_emit_r   <= (op != OP_MAJ) || in_last_node;
      s1_rinv_r   <= in_root_invert;
      s1_const_r  <= const_val;
      s1_wr_en_r  <= 32'(node_idx_r) < MAX_NODES;
      s1_wr_idx_r <= node_idx_r;
      for (int k = 0; k < 3; k++) begin
        s1_child_r[k] <= child_src[k];
      end
    end
  end

  // store reads
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_a_r <= mem0[rd_addr[0]];
      rd_b_r <= mem0[rd_addr[1]];
      rd_c_r <= mem1[rd_addr[2]];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: operand select, majority, write back
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [TT_W-1:0] rd [3];
    rd[0] = rd_a_r;
    rd[1] = rd_b_r;
    rd[2] = rd_c_r;
    for (int k = 0; k < 3; k++) begin
      if (s1_child_r[k].use_fwd) begin
        child_val[k] = fwd_data_r;
      end else if (s1_child_r[k].use_mem) begin
        child_val[k] = rd[k];
      end else begin
        child_val[k] = s1_child_r[k].leaf_val;
      end
      child_val[k] = child_val[k] ^ {TT_W{s1_child_r[k].inv}};
    end
    maj_val = (child_val[0] & child_val[1]) | (child_val[0] & child_val[2]) |
              (child_val[1] & child_val[2]);
    s1_result = s1_is_maj_r ? (maj_val ^ {TT_W{s1_rinv_r}}) : s1_const_r;
  end

  assign wr_ext  = {{AW{1'b0}}, s1_wr_idx_r};
  assign wr_addr = wr_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (s1_fire && s1_is_maj_r && s1_wr_en_r) begin
      mem0[wr_addr] <= maj_val;
      mem1[wr_addr] <= maj_val;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_is_maj_r) begin
      fwd_data_r <= maj_val;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit_r) begin
      out_tt_r <= s1_result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_truth_table = out_tt_r;

`ifndef SYNTHESIS
  // back-pressure only comes from a pending result behind a full output reg
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_emit_r && out_valid_r && !out_ready))
    else $error("input stalled without output back-pressure");

  // a held stage keeps its store write target
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=> (s1_valid_r && $stable(s1_wr_idx_r)))
    else $error("stage 1 lost its word while stalled");

  // forwarding only ever replaces a store read
  a_fwd_mem: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> ((!s1_child_r[0].use_fwd || s1_child_r[0].use_mem) &&
                    (!s1_child_r[1].use_fwd || s1_child_r[1].use_mem) &&
                    (!s1_child_r[2].use_fwd || s1_child_r[2].use_mem)))
    else $error("forward selected for a leaf operand");

  // end of a graph restarts node numbering at the leaf count
  a_cnt_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && op == OP_MAJ && in_last_node) |=>
      (node_idx_r == {{(CNT_W-LC_W){1'b0}}, leaf_count_r}))
    else $error("node counter did not restart");
`endif

endmodule

`default_nettype wire
